// ----- rtl/core/uvt_pkg.sv -----
// Package for the unique vector tally block: sizes, entry types, control
// struct between the sequencer and the entry cells, and helper functions.
// No dependencies.
package uvt_pkg;

  // Configuration of the table
  localparam int unsigned VECTOR_BITS = 32;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned COUNT_BITS  = 16;

  // Derived widths
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(TABLE_DEPTH + 1);

  // Port field widths
  localparam int unsigned MEMBER_W = 32;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned ECOUNT_W = 16;

  typedef logic [VECTOR_BITS-1:0] vec_t;
  typedef logic [COUNT_BITS-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [OCC_W-1:0]       occ_t;

  localparam cnt_t COUNT_MAX = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Control broadcast to every cell
  typedef struct packed {
    logic shift;       // rotate the table one place towards the head
    logic append;      // store the query in the cell at append_idx
    idx_t append_idx;
  } cell_ctl_t;

  // Keep the vector bits that take part in the comparison
  function automatic vec_t to_vec(logic [MEMBER_W-1:0] m);
    logic [63:0] ext;
    ext = {32'b0, m};
    return ext[VECTOR_BITS-1:0];
  endfunction

  // Saturating increment of an entry count
  function automatic cnt_t sat_inc(cnt_t c);
    return (c == COUNT_MAX) ? c : c + cnt_t'(1);
  endfunction

endpackage

// ----- rtl/core/unique_vector_tally.sv -----
// Unique vector tally: counts occurrences of distinct 32-bit membership
// vectors in a table of TABLE_DEPTH entries held in a rotating row of cells.
// Each item passes through a transfer, one full rotation of the table past
// the single head comparator and an update step, which waits until the
// previous result has left. One item is in work at a time, and the next
// item is taken while a finished result waits to be transferred. A set
// clear_first empties the table before its item is handled. A miss on a
// full table reports table_full with the other fields zero; counts saturate.
// Depends on uvt_pkg, uvt_cell and uvt_ctrl.
module unique_vector_tally (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [uvt_pkg::MEMBER_W-1:0] member_bits_i,
  input  logic                         clear_first_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [uvt_pkg::INDEX_W-1:0]  entry_index_o,
  output logic                         is_new_o,
  output logic [uvt_pkg::ECOUNT_W-1:0] entry_count_o,
  output logic                         table_full_o
);
  import uvt_pkg::*;

  vec_t      cell_vec [TABLE_DEPTH];
  cnt_t      cell_cnt [TABLE_DEPTH];
  cnt_t      wb_cnt;
  vec_t      query;
  cell_ctl_t ctl;

  // Sequencer with the head comparator
  uvt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .member_bits_i (member_bits_i),
    .clear_first_i (clear_first_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .entry_index_o (entry_index_o),
    .is_new_o      (is_new_o),
    .entry_count_o (entry_count_o),
    .table_full_o  (table_full_o),
    .head_vec_i    (cell_vec[0]),
    .head_cnt_i    (cell_cnt[0]),
    .wb_cnt_o      (wb_cnt),
    .query_o       (query),
    .ctl_o         (ctl)
  );

  // Row of entry cells; the head wraps round to the tail with its new count
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    vec_t nbr_vec;
    cnt_t nbr_cnt;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nbr_vec = cell_vec[0];
      assign nbr_cnt = wb_cnt;
    end else begin : g_body
      assign nbr_vec = cell_vec[i+1];
      assign nbr_cnt = cell_cnt[i+1];
    end

    uvt_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .cell_idx_i (idx_t'(i)),
      .nbr_vec_i  (nbr_vec),
      .nbr_cnt_i  (nbr_cnt),
      .load_vec_i (query),
      .vec_o      (cell_vec[i]),
      .cnt_o      (cell_cnt[i])
    );
  end

`ifndef NO_ASSERTIONS
  // A transfer in starts a scan, so the input is closed the cycle after
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again while a scan is running");

  // A full-table miss reports nothing but the flag
  a_full_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (!is_new_o && entry_count_o == '0 &&
                                       entry_index_o == '0))
    else $error("full result carries entry fields");

  // A new entry always starts at count one
  a_new_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_new_o) |-> (entry_count_o == ECOUNT_W'(1) && !table_full_o))
    else $error("new entry with wrong count");

  // Table is never shifted while an append is stored
  a_shift_append : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.shift && ctl.append))
    else $error("shift and append in the same cycle");
`endif

endmodule

// ----- rtl/core/uvt_cell.sv -----
// One table entry: a stored vector and its count, part of a rotating row.
// Depends on uvt_pkg.
module uvt_cell (
  input  logic             clk_i,
  input  uvt_pkg::cell_ctl_t ctl_i,
  input  uvt_pkg::idx_t    cell_idx_i,
  input  uvt_pkg::vec_t    nbr_vec_i,
  input  uvt_pkg::cnt_t    nbr_cnt_i,
  input  uvt_pkg::vec_t    load_vec_i,
  output uvt_pkg::vec_t    vec_o,
  output uvt_pkg::cnt_t    cnt_o
);
  import uvt_pkg::*;

  vec_t vec_q;
  cnt_t cnt_q;
  logic load;

  assign load = ctl_i.append && (ctl_i.append_idx == cell_idx_i);

  // Entry storage: shift from the neighbour, or take a new vector
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      vec_q <= nbr_vec_i;
      cnt_q <= nbr_cnt_i;
    end else if (load) begin
      vec_q <= load_vec_i;
      cnt_q <= cnt_t'(1);
    end
  end

  assign vec_o = vec_q;
  assign cnt_o = cnt_q;

endmodule

// ----- rtl/core/uvt_ctrl.sv -----
// Sequencer: takes an item, rotates the table once past the head comparator,
// updates or appends the entry and holds the result until transferred.
// Depends on uvt_pkg.
module uvt_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [uvt_pkg::MEMBER_W-1:0] member_bits_i,
  input  logic                     clear_first_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [uvt_pkg::INDEX_W-1:0]  entry_index_o,
  output logic                     is_new_o,
  output logic [uvt_pkg::ECOUNT_W-1:0] entry_count_o,
  output logic                     table_full_o,
  input  uvt_pkg::vec_t            head_vec_i,
  input  uvt_pkg::cnt_t            head_cnt_i,
  output uvt_pkg::cnt_t            wb_cnt_o,
  output uvt_pkg::vec_t            query_o,
  output uvt_pkg::cell_ctl_t       ctl_o
);
  import uvt_pkg::*;

  state_e state_q, state_d;
  occ_t   occ_q, occ_d;
  occ_t   step_q, step_d;
  logic   hit_q, hit_d;
  idx_t   hit_idx_q, hit_idx_d;
  cnt_t   hit_cnt_q, hit_cnt_d;
  vec_t   query_q, query_d;

  logic                out_valid_q, out_valid_d;
  logic [INDEX_W-1:0]  index_q, index_d;
  logic                new_q, new_d;
  logic [ECOUNT_W-1:0] count_q, count_d;
  logic                full_q, full_d;

  logic       head_match;
  logic [31:0] idx_ext, cnt_ext;

  // Head comparator: only entries below the occupancy take part
  assign head_match = (step_q < occ_q) && (head_vec_i == query_q);
  assign wb_cnt_o   = head_match ? sat_inc(head_cnt_i) : head_cnt_i;

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    step_d      = step_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_cnt_d   = hit_cnt_q;
    query_d     = query_q;
    out_valid_d = out_valid_q;
    index_d     = index_q;
    new_d       = new_q;
    count_d     = count_q;
    full_d      = full_q;
    ctl_o       = '0;
    idx_ext     = '0;
    cnt_ext     = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          query_d = to_vec(member_bits_i);
          if (clear_first_i) begin
            occ_d = '0;
          end
          step_d  = '0;
          hit_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl_o.shift = 1'b1;
        if (head_match) begin
          hit_d     = 1'b1;
          hit_idx_d = step_q[IDX_W-1:0];
          hit_cnt_d = sat_inc(head_cnt_i);
        end
        step_d = step_q + occ_t'(1);
        if (step_q == occ_t'(TABLE_DEPTH - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait for the previous result to leave
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (hit_q) begin
            idx_ext = 32'(hit_idx_q);
            cnt_ext = 32'(hit_cnt_q);
            index_d = idx_ext[INDEX_W-1:0];
            new_d   = 1'b0;
            count_d = cnt_ext[ECOUNT_W-1:0];
            full_d  = 1'b0;
          end else if (occ_q < occ_t'(TABLE_DEPTH)) begin
            ctl_o.append     = 1'b1;
            ctl_o.append_idx = occ_q[IDX_W-1:0];
            idx_ext = 32'(occ_q);
            index_d = idx_ext[INDEX_W-1:0];
            new_d   = 1'b1;
            count_d = ECOUNT_W'(1);
            full_d  = 1'b0;
            occ_d   = occ_q + occ_t'(1);
          end else begin
            index_d = '0;
            new_d   = 1'b0;
            count_d = '0;
            full_d  = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      step_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      step_q      <= step_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    hit_cnt_q <= hit_cnt_d;
    query_q   <= query_d;
    index_q   <= index_d;
    new_q     <= new_d;
    count_q   <= count_d;
    full_q    <= full_d;
  end

  assign query_o       = query_q;
  assign out_valid_o   = out_valid_q;
  assign entry_index_o = index_q;
  assign is_new_o      = new_q;
  assign entry_count_o = count_q;
  assign table_full_o  = full_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for unique_vector_tally: drives member vectors with
// random idling on both valid/ready channels and checks every result.
// Depends on uvt_pkg and the unique_vector_tally RTL.
`timescale 1ns / 100ps

module testbench;
  import uvt_pkg::*;

  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned MAX_PRINTS  = 50;

  // One expected or observed result
  typedef struct packed {
    logic [INDEX_W-1:0]  index;
    logic                is_new;
    logic [ECOUNT_W-1:0] count;
    logic                full;
  } tally_t;

  // Own copy of the distinct-vector table plus the queue of pending results
  class tally_scoreboard;
    vec_t        stored[TABLE_DEPTH];
    cnt_t        counts[TABLE_DEPTH];
    int unsigned used;
    tally_t      tally_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned new_seen;
    int unsigned full_seen;

    function new();
      used      = 0;
      errors    = 0;
      checked   = 0;
      new_seen  = 0;
      full_seen = 0;
    endfunction

    function int unsigned pending();
      return tally_q.size();
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    // Work out the result of one accepted input transfer
    function void note_input(logic [MEMBER_W-1:0] member, logic clear);
      logic [63:0] wide;
      vec_t        vec;
      int unsigned pos;
      bit          hit;
      tally_t      res;
      wide = 64'(member);
      vec  = wide[VECTOR_BITS-1:0];
      hit  = 1'b0;
      pos  = 0;
      if (clear) used = 0;
      for (int unsigned i = 0; i < used; i++) begin
        if (stored[i] == vec) begin
          hit = 1'b1;
          pos = i;
          break;
        end
      end
      if (hit) begin
        if (counts[pos] != COUNT_MAX) counts[pos] = counts[pos] + cnt_t'(1);
        res = '{index: INDEX_W'(pos), is_new: 1'b0, count: ECOUNT_W'(counts[pos]), full: 1'b0};
      end else if (used < TABLE_DEPTH) begin
        stored[used] = vec;
        counts[used] = cnt_t'(1);
        res = '{index: INDEX_W'(used), is_new: 1'b1, count: ECOUNT_W'(1), full: 1'b0};
        used++;
      end else begin
        // miss on a full table: nothing stored
        res = '{index: '0, is_new: 1'b0, count: '0, full: 1'b1};
      end
      tally_q = {tally_q, res};
    endfunction

    // Compare one output transfer with the oldest pending result
    function void check_result(tally_t got);
      tally_t want;
      if (tally_q.size() == 0) begin
        report($sformatf("unexpected result idx=%0d new=%0b cnt=%0d full=%0b",
                         got.index, got.is_new, got.count, got.full));
        return;
      end
      want = tally_q.pop_front();
      checked++;
      if (want.is_new) new_seen++;
      if (want.full) full_seen++;
      if (got.index !== want.index)
        report($sformatf("entry_index %0d, expected %0d", got.index, want.index));
      if (got.is_new !== want.is_new)
        report($sformatf("is_new %0b, expected %0b", got.is_new, want.is_new));
      if (got.count !== want.count)
        report($sformatf("entry_count %0d, expected %0d", got.count, want.count));
      if (got.full !== want.full)
        report($sformatf("table_full %0b, expected %0b", got.full, want.full));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [MEMBER_W-1:0] member_bits_i = '0;
  logic                clear_first_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [INDEX_W-1:0]  entry_index_o;
  logic                is_new_o;
  logic [ECOUNT_W-1:0] entry_count_o;
  logic                table_full_o;

  tally_scoreboard sb = new();
  int unsigned     items_sent = 0;
  bit              no_idle    = 1'b0;
  int unsigned     hold_req   = 0;

  unique_vector_tally i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .member_bits_i (member_bits_i),
    .clear_first_i (clear_first_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .entry_index_o (entry_index_o),
    .is_new_o      (is_new_o),
    .entry_count_o (entry_count_o),
    .table_full_o  (table_full_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input logic [MEMBER_W-1:0] member, input logic clear);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    member_bits_i <= member;
    clear_first_i <= clear;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(member, clear);
    items_sent++;
  endtask

  // Sender pause: wait until every pending result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  // Result side: random stalls before or after valid shows, plus the long hold
  initial begin
    int unsigned gap;
    bit          after_valid;
    tally_t      got;
    @(posedge rst_ni);
    forever begin
      gap         = no_idle ? 0 : $urandom_range(0, 12);
      after_valid = $urandom_range(0, 1);
      if (hold_req > 0) begin
        gap         = hold_req;
        hold_req    = 0;
        after_valid = 1'b0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        if (after_valid) begin
          do @(posedge clk_i); while (!out_valid_o);
        end
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = '{index: entry_index_o, is_new: is_new_o, count: entry_count_o,
              full: table_full_o};
      sb.check_result(got);
    end
  end

  // Watchdog: too long without any transfer ends the run
  initial begin
    int unsigned stall;
    stall = 0;
    @(posedge rst_ni);
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall = 0;
      else stall++;
    end
    $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin
    logic [MEMBER_W-1:0] pool[24];
    logic [MEMBER_W-1:0] big_pool[TABLE_DEPTH];
    int unsigned         pool_n;
    int unsigned         set_len;
    int unsigned         r;
    bit                  big_done;
    bit                  start_clear;
    logic [MEMBER_W-1:0] member;

    big_done = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, hits, clear with an item, walking bits
    send_item('0, 1'b0);
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item('1, 1'b0);
    send_item(32'h8000_0001, 1'b0);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item('0, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item('1, 1'b1);          // clear then insert: entry 0, count one
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item('0, 1'b1);
    send_item('0, 1'b1);          // clear on a vector that was just stored
    for (int unsigned b = 0; b < 32; b += 6) send_item(MEMBER_W'(1) << b, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    wait_drained();

    // Pressure: receiver holds off while items keep coming back to back
    no_idle  = 1'b1;
    hold_req = HOLD_CYCLES;
    for (int unsigned n = 0; n < 6; n++) send_item($urandom(), 1'b0);
    no_idle = 1'b0;
    wait_drained();

    // Random sets
    while (items_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if (!big_done && items_sent >= 500) begin
        // Fill the whole table, then mix misses on the full table with hits
        for (int unsigned k = 0; k < TABLE_DEPTH; k++) begin
          big_pool[k] = $urandom();
          send_item(big_pool[k], k == 0);
        end
        for (int unsigned n = 0; n < 40; n++) begin
          if ($urandom_range(0, 1)) send_item($urandom(), 1'b0);
          else send_item(big_pool[$urandom_range(0, TABLE_DEPTH - 1)], 1'b0);
        end
        send_item(big_pool[TABLE_DEPTH-1], 1'b0);
        big_done = 1'b1;
      end else begin
        // Small pool with near-miss neighbours, mostly repeats
        pool_n = $urandom_range(1, 24);
        for (int unsigned k = 0; k < pool_n; k++) begin
          if (k > 0 && $urandom_range(0, 3) == 0)
            pool[k] = pool[k-1] ^ (MEMBER_W'(1) << $urandom_range(0, MEMBER_W - 1));
          else
            pool[k] = $urandom();
        end
        set_len     = $urandom_range(4, 40);
        start_clear = ($urandom_range(0, 4) != 0);
        for (int unsigned n = 0; n < set_len; n++) begin
          r      = $urandom_range(0, 99);
          member = (r < 88) ? pool[$urandom_range(0, pool_n - 1)] : $urandom();
          send_item(member, (n == 0 && start_clear) || r < 3);
        end
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    // Drain, then allow time for any stray result
    wait_drained();
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk_i);

    $display("Run: %0d input transfers, %0d results checked", items_sent, sb.checked);
    $display("     %0d new entries, %0d table-full misses, %0d errors",
             sb.new_seen, sb.full_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
